>>> rtl/core/sshp_pkg.sv
// ----------------------------------------------------------------------------
// sshp_pkg: shared types and constants of the separable sharpening filter
// Holds the fixed-point widths, kernel weights, opcodes and the structs that
// carry configuration, commands and status between the modules.
// ----------------------------------------------------------------------------
package sshp_pkg;

    // Fixed-point widths.
    localparam int IN_W   = 24;              // input component, signed Q11
    localparam int XW     = 26;              // stored x-filtered value, signed
    localparam int WT_W   = 13;              // kernel weight, signed
    localparam int FRAC   = 11;              // fraction bits of the weights
    localparam int PROD_W = XW + WT_W;       // one weighted product
    localparam int TERM_W = PROD_W - FRAC;   // one rounded term
    localparam int SUM_W  = TERM_W + 2;      // sum of three terms
    localparam int Q_W    = SUM_W - FRAC;    // final rounded value
    localparam int OUT_W  = 8;

    // Kernel weights and rounding constants.
    localparam logic signed [WT_W-1:0]   W_SIDE = -13'sd506;
    localparam logic signed [WT_W-1:0]   W_MID  = 13'sd3060;
    localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(1024);
    localparam logic signed [SUM_W-1:0]  HALF_S = SUM_W'(1024);
    localparam logic signed [Q_W-1:0]    Q_MAX  = Q_W'(255);

    // Ring of line buffers.
    localparam int RING_ROWS = 3;
    localparam int SLOT_W    = 2;
    localparam logic [SLOT_W-1:0] SLOT_LAST = 2'd2;

    // Port-level constants.
    localparam int PORT_COMPS = 4;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_COMPS  = 2'd2;

    // Request opcodes.
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic [10:0] width;
        logic [15:0] height;
        logic [2:0]  comps;
    } t_cfg;

    typedef struct packed {
        logic              latch_in;    // capture the incoming pixel
        logic              shift_pix;   // move current pixel into history
        logic              phase_y;     // multiplier operands from line store
        logic              tap_last;    // x taps for the last column of a row
        logic              first_col;   // x taps replicate the left edge
        logic              sum_en;      // register the lane sums
        logic              wr_en;       // write x result into the tail row
        logic              below_rd;    // lower y tap comes from the mid row
        logic [SLOT_W-1:0] above_slot;
        logic [SLOT_W-1:0] mid_slot;
        logic [SLOT_W-1:0] tail_slot;
        logic              load_out;    // load the output register
        logic              row_end;
        logic              frame_end;
        logic              last_run;
        logic [2:0]        n_eff;       // components in use
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

>>> rtl/core/separable_sharpen_3x3.sv
// ----------------------------------------------------------------------------
// separable_sharpen_3x3: 3x3 separable sharpening filter on a pixel stream
// Pixels arrive in row order with up to four signed Q11 components. The block
// applies the kernel (-506, 3060, -506)/2048 along x and then along y with
// edge replication, rounds and clamps each component to 0..255, and emits
// each output row one row late; drain requests emit the final row. One
// request is worked at a time by a sequencer that runs the same multiply
// lanes once for the x pass and once for the y pass of every pixel. A push
// at column 0 only captures its pixel, the last push of a row runs both
// passes again for the last column (two results on a later row), a drain
// request runs only the y pass, and a stalled output holds the sequencer
// until the result can load. Results wait in an output register, so a
// finished result does not hold off the next request. The line store needs
// no clearing after reset.
// ----------------------------------------------------------------------------
module separable_sharpen_3x3 #(
    parameter int MAX_WIDTH      = 1024,
    parameter int MAX_COMPONENTS = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Pixel requests.
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_op,
    input  logic signed [sshp_pkg::IN_W-1:0]   i_comp0_in,
    input  logic signed [sshp_pkg::IN_W-1:0]   i_comp1_in,
    input  logic signed [sshp_pkg::IN_W-1:0]   i_comp2_in,
    input  logic signed [sshp_pkg::IN_W-1:0]   i_comp3_in,
    // Result requests.
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [sshp_pkg::OUT_W-1:0]         o_comp0_out,
    output logic [sshp_pkg::OUT_W-1:0]         o_comp1_out,
    output logic [sshp_pkg::OUT_W-1:0]         o_comp2_out,
    output logic [sshp_pkg::OUT_W-1:0]         o_comp3_out,
    output logic                               o_row_end,
    output logic                               o_frame_end,
    output logic                               o_last_of_run,
    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sshp_pkg::ADDR_W-1:0]        paddr,
    input  logic [sshp_pkg::DATA_W-1:0]        pwdata,
    output logic [sshp_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);

    localparam int AW = $clog2(MAX_WIDTH);

    sshp_pkg::t_cfg                   w_cfg;
    logic                             w_cfg_wr;
    sshp_pkg::t_cmd                   w_cmd;
    sshp_pkg::t_status                w_status;
    logic [AW-1:0]                    w_col;
    logic signed [sshp_pkg::IN_W-1:0] w_port_in  [sshp_pkg::PORT_COMPS];
    logic [sshp_pkg::OUT_W-1:0]       w_port_out [sshp_pkg::PORT_COMPS];
    logic signed [sshp_pkg::IN_W-1:0] w_lane_in  [MAX_COMPONENTS];
    logic [sshp_pkg::OUT_W-1:0]       w_lane_out [MAX_COMPONENTS];

    assign w_port_in[0] = i_comp0_in;
    assign w_port_in[1] = i_comp1_in;
    assign w_port_in[2] = i_comp2_in;
    assign w_port_in[3] = i_comp3_in;

    // Map the fixed component ports onto the configured lanes.
    for (genvar k = 0; k < sshp_pkg::PORT_COMPS; k++) begin : g_port
        if (k < MAX_COMPONENTS) begin : g_used
            assign w_lane_in[k]  = w_port_in[k];
            assign w_port_out[k] = w_lane_out[k];
        end else begin : g_unused
            assign w_port_out[k] = '0;
        end
    end

    assign o_comp0_out = w_port_out[0];
    assign o_comp1_out = w_port_out[1];
    assign o_comp2_out = w_port_out[2];
    assign o_comp3_out = w_port_out[3];

    sshp_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (w_cfg),
        .o_cfg_wr (w_cfg_wr)
    );

    sshp_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .o_in_stall (o_in_stall),
        .i_cfg      (w_cfg),
        .i_cfg_wr   (w_cfg_wr),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_col      (w_col)
    );

    sshp_dp #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_COMPONENTS (MAX_COMPONENTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_col         (w_col),
        .i_comp        (w_lane_in),
        .i_out_stall   (i_out_stall),
        .o_status      (w_status),
        .o_out_valid   (o_out_valid),
        .o_comp        (w_lane_out),
        .o_row_end     (o_row_end),
        .o_frame_end   (o_frame_end),
        .o_last_of_run (o_last_of_run)
    );

endmodule

>>> rtl/core/sshp_regs.sv
// ----------------------------------------------------------------------------
// sshp_regs: configuration register bank
// APB-style slave holding image width, image height and component count.
// Flags every write to a defined register; an idle sequencer then restarts the frame position.
// ----------------------------------------------------------------------------
module sshp_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sshp_pkg::ADDR_W-1:0]    paddr,
    input  logic [sshp_pkg::DATA_W-1:0]    pwdata,
    output logic [sshp_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    output sshp_pkg::t_cfg                 o_cfg,
    output logic                           o_cfg_wr
);

    sshp_pkg::t_cfg r_cfg;
    logic           w_wr;
    logic [1:0]     w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite && pready;

    // A write to any defined register restarts the frame if the sequencer is idle.
    assign o_cfg_wr = w_wr && (w_idx == sshp_pkg::REG_WIDTH ||
                               w_idx == sshp_pkg::REG_HEIGHT ||
                               w_idx == sshp_pkg::REG_COMPS);
    assign o_cfg    = r_cfg;

    // Register storage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= 11'd1024;
            r_cfg.height <= 16'd480;
            r_cfg.comps  <= 3'd3;
        end else if (w_wr) begin
            case (w_idx)
                sshp_pkg::REG_WIDTH:  r_cfg.width  <= pwdata[10:0];
                sshp_pkg::REG_HEIGHT: r_cfg.height <= pwdata[15:0];
                sshp_pkg::REG_COMPS:  r_cfg.comps  <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        case (w_idx)
            sshp_pkg::REG_WIDTH:  prdata = sshp_pkg::DATA_W'(r_cfg.width);
            sshp_pkg::REG_HEIGHT: prdata = sshp_pkg::DATA_W'(r_cfg.height);
            sshp_pkg::REG_COMPS:  prdata = sshp_pkg::DATA_W'(r_cfg.comps);
            default:              prdata = '0;
        endcase
    end

endmodule

>>> rtl/core/sshp_dp.sv
// ----------------------------------------------------------------------------
// sshp_dp: filter datapath
// Pixel history, three line-buffer banks, per-component multiply and sum
// lanes shared by the x and y passes, and the output register.
// ----------------------------------------------------------------------------
module sshp_dp #(
    parameter  int MAX_WIDTH      = 1024,
    parameter  int MAX_COMPONENTS = 4,
    localparam int AW             = $clog2(MAX_WIDTH)
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  sshp_pkg::t_cmd                            i_cmd,
    input  logic [AW-1:0]                             i_col,
    input  logic signed [sshp_pkg::IN_W-1:0]          i_comp [MAX_COMPONENTS],
    input  logic                                      i_out_stall,
    output sshp_pkg::t_status                         o_status,
    output logic                                      o_out_valid,
    output logic [sshp_pkg::OUT_W-1:0]                o_comp [MAX_COMPONENTS],
    output logic                                      o_row_end,
    output logic                                      o_frame_end,
    output logic                                      o_last_of_run
);

    localparam int XW   = sshp_pkg::XW;
    localparam int LW   = XW * MAX_COMPONENTS;
    localparam int NTAP = 3;

    logic signed [sshp_pkg::IN_W-1:0]   r_cur  [MAX_COMPONENTS];
    logic signed [sshp_pkg::IN_W-1:0]   r_p1   [MAX_COMPONENTS];
    logic signed [sshp_pkg::IN_W-1:0]   r_p2   [MAX_COMPONENTS];
    logic signed [sshp_pkg::PROD_W-1:0] r_prod [MAX_COMPONENTS][NTAP];
    logic signed [sshp_pkg::SUM_W-1:0]  r_sum  [MAX_COMPONENTS];
    logic [sshp_pkg::OUT_W-1:0]         r_out  [MAX_COMPONENTS];
    logic [LW-1:0]                      r_rd   [sshp_pkg::RING_ROWS];
    logic [LW-1:0]                      w_rd_above;
    logic [LW-1:0]                      w_rd_mid;
    logic [LW-1:0]                      w_wr_word;
    logic                               r_out_valid;
    logic                               r_row_end;
    logic                               r_frame_end;
    logic                               r_last;

    // Line-buffer banks, one per ring slot; every bank reads at the pass column.
    for (genvar g = 0; g < sshp_pkg::RING_ROWS; g++) begin : g_bank
        logic [LW-1:0] r_mem [MAX_WIDTH];

        always_ff @(posedge i_clk) begin
            if (i_cmd.wr_en && i_cmd.tail_slot == sshp_pkg::SLOT_W'(g)) begin
                r_mem[i_col] <= w_wr_word;
            end
            r_rd[g] <= r_mem[i_col];
        end
    end

    // Pick the rows above and in the middle from the registered bank outputs.
    always_comb begin
        case (i_cmd.above_slot)
            2'd0:    w_rd_above = r_rd[0];
            2'd1:    w_rd_above = r_rd[1];
            default: w_rd_above = r_rd[2];
        endcase
        case (i_cmd.mid_slot)
            2'd0:    w_rd_mid = r_rd[0];
            2'd1:    w_rd_mid = r_rd[1];
            default: w_rd_mid = r_rd[2];
        endcase
    end

    // One lane per component.
    for (genvar k = 0; k < MAX_COMPONENTS; k++) begin : g_lane
        logic signed [XW-1:0]                w_op   [NTAP];
        logic signed [sshp_pkg::PROD_W-1:0]  w_rnd  [NTAP];
        logic signed [sshp_pkg::TERM_W-1:0]  w_term [NTAP];
        logic signed [sshp_pkg::SUM_W-1:0]   w_sum;
        logic signed [sshp_pkg::SUM_W-1:0]   w_fin;
        logic signed [sshp_pkg::Q_W-1:0]     w_q;
        logic [sshp_pkg::OUT_W-1:0]          w_clip;
        logic                                w_used;

        assign w_used = (k < int'(i_cmd.n_eff));

        // Pixel history: capture on accept, shift when the request finishes.
        always_ff @(posedge i_clk) begin
            if (i_cmd.latch_in) begin
                r_cur[k] <= w_used ? i_comp[k] : '0;
            end
            if (i_cmd.shift_pix) begin
                r_p2[k] <= r_p1[k];
                r_p1[k] <= r_cur[k];
            end
        end

        // Multiplier operands: pixel taps along x, stored rows along y.
        always_comb begin
            if (i_cmd.phase_y) begin
                w_op[0] = $signed(w_rd_above[k*XW +: XW]);
                w_op[1] = $signed(w_rd_mid[k*XW +: XW]);
                w_op[2] = i_cmd.below_rd ? $signed(w_rd_mid[k*XW +: XW])
                                         : $signed(r_sum[k][XW-1:0]);
            end else begin
                w_op[0] = XW'((i_cmd.tap_last || i_cmd.first_col) ? r_p1[k] : r_p2[k]);
                w_op[1] = XW'(i_cmd.tap_last ? r_cur[k] : r_p1[k]);
                w_op[2] = XW'(r_cur[k]);
            end
        end

        // Weighted products, then each term rounded to a whole Q11 step.
        for (genvar t = 0; t < NTAP; t++) begin : g_tap
            localparam logic signed [sshp_pkg::WT_W-1:0] WT =
                (t == 1) ? sshp_pkg::W_MID : sshp_pkg::W_SIDE;

            always_ff @(posedge i_clk) begin
                r_prod[k][t] <= w_op[t] * WT;
            end

            assign w_rnd[t]  = r_prod[k][t] + sshp_pkg::HALF_P;
            assign w_term[t] = $signed(w_rnd[t][sshp_pkg::PROD_W-1:sshp_pkg::FRAC]);
        end

        assign w_sum = sshp_pkg::SUM_W'(w_term[0]) + sshp_pkg::SUM_W'(w_term[1]) +
                       sshp_pkg::SUM_W'(w_term[2]);

        always_ff @(posedge i_clk) begin
            if (i_cmd.sum_en) begin
                r_sum[k] <= w_sum;
            end
        end

        assign w_wr_word[k*XW +: XW] = r_sum[k][XW-1:0];

        // Final rounding to an integer and clamping to 0..255.
        assign w_fin = r_sum[k] + sshp_pkg::HALF_S;
        assign w_q   = $signed(w_fin[sshp_pkg::SUM_W-1:sshp_pkg::FRAC]);

        always_comb begin
            if (w_q[sshp_pkg::Q_W-1]) begin
                w_clip = '0;
            end else if (w_q > sshp_pkg::Q_MAX) begin
                w_clip = '1;
            end else begin
                w_clip = w_q[sshp_pkg::OUT_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.load_out) begin
                r_out[k] <= w_used ? w_clip : '0;
            end
        end

        assign o_comp[k] = r_out[k];
    end

    // Output register flags.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_row_end   <= i_cmd.row_end;
            r_frame_end <= i_cmd.frame_end;
            r_last      <= i_cmd.last_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_row_end         = r_row_end;
    assign o_frame_end       = r_frame_end;
    assign o_last_of_run     = r_last;

    // The row being written is never one of the rows being read.
    a_wr_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> (i_cmd.tail_slot != i_cmd.mid_slot) &&
                        (i_cmd.tail_slot != i_cmd.above_slot))
        else $error("line store write targets a row that is being read");

endmodule

>>> rtl/core/sshp_ctrl.sv
// ----------------------------------------------------------------------------
// sshp_ctrl: request sequencer
// Tracks the frame position and the line-buffer ring, and steps the datapath
// through the x pass, the y pass and the output of each result.
// ----------------------------------------------------------------------------
module sshp_ctrl #(
    parameter  int MAX_WIDTH = 1024,
    localparam int AW        = $clog2(MAX_WIDTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_op,
    output logic               o_in_stall,
    input  sshp_pkg::t_cfg     i_cfg,
    input  logic               i_cfg_wr,
    input  sshp_pkg::t_status  i_status,
    output sshp_pkg::t_cmd     o_cmd,
    output logic [AW-1:0]      o_col
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (CW > 11) ? CW : 11;

    typedef enum logic [2:0] {
        S_IDLE,
        S_XMUL,
        S_XSUM,
        S_YMUL,
        S_YSUM,
        S_YOUT,
        S_RD,
        S_FIN
    } t_state;

    t_state                      r_state;
    logic [AW-1:0]               r_col;
    logic [AW-1:0]               r_pcol;
    logic [AW-1:0]               r_drain;
    logic [15:0]                 r_row;
    logic [sshp_pkg::SLOT_W-1:0] r_tail;
    logic [sshp_pkg::SLOT_W-1:0] r_head;
    logic                        r_pass_b;
    logic                        r_drain_mode;

    logic [EW-1:0]               w_wc;
    logic [EW-1:0]               w_w_eff;
    logic [EW-1:0]               w_last_x;
    logic [15:0]                 w_h_eff;
    logic [2:0]                  w_n_eff;
    logic                        w_col_last;
    logic                        w_drain_last;
    logic                        w_row_done;
    logic                        w_emit;
    logic                        w_more;
    logic [sshp_pkg::SLOT_W-1:0] w_mid;
    logic [sshp_pkg::SLOT_W-1:0] w_tail_nx;
    logic [sshp_pkg::SLOT_W-1:0] w_head_nx;

    // Effective frame geometry.
    always_comb begin
        w_wc = EW'(i_cfg.width);
        if (w_wc < EW'(2)) begin
            w_w_eff = EW'(2);
        end else if (w_wc > EW'(MAX_WIDTH)) begin
            w_w_eff = EW'(MAX_WIDTH);
        end else begin
            w_w_eff = w_wc;
        end
    end

    assign w_last_x     = w_w_eff - EW'(1);
    assign w_h_eff      = (i_cfg.height < 16'd2) ? 16'd2 : i_cfg.height;
    assign w_n_eff      = (i_cfg.comps > 3'd4) ? 3'd4 : i_cfg.comps;
    assign w_col_last   = (EW'(r_col) == w_last_x);
    assign w_drain_last = (EW'(r_drain) == w_last_x);
    assign w_row_done   = (r_row >= w_h_eff);
    assign w_emit       = (r_row != 16'd0);
    assign w_more       = !r_drain_mode && !r_pass_b && w_col_last;

    // Ring slots: middle row is the one before the tail, head follows the tail.
    always_comb begin
        case (r_tail)
            2'd0:    w_mid = 2'd2;
            2'd1:    w_mid = 2'd0;
            default: w_mid = 2'd1;
        endcase
    end

    assign w_tail_nx = (r_tail == sshp_pkg::SLOT_LAST) ? '0 : r_tail + 2'd1;
    assign w_head_nx = (w_tail_nx == sshp_pkg::SLOT_LAST) ? '0 : w_tail_nx + 2'd1;

    // Sequencer and frame position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_col        <= '0;
            r_pcol       <= '0;
            r_drain      <= '0;
            r_row        <= '0;
            r_tail       <= '0;
            r_head       <= '0;
            r_pass_b     <= 1'b0;
            r_drain_mode <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_wr) begin
                        r_col   <= '0;
                        r_drain <= '0;
                        r_row   <= '0;
                        r_tail  <= '0;
                        r_head  <= '0;
                    end else if (i_in_valid) begin
                        r_pass_b <= 1'b0;
                        if (i_op == sshp_pkg::OP_PUSH) begin
                            r_drain_mode <= 1'b0;
                            if (!w_row_done) begin
                                if (r_col != '0) begin
                                    r_pcol  <= r_col - AW'(1);
                                    r_state <= S_XMUL;
                                end else begin
                                    r_state <= S_FIN;
                                end
                            end
                        end else begin
                            r_drain_mode <= 1'b1;
                            if (w_row_done) begin
                                r_pcol  <= r_drain;
                                r_state <= S_RD;
                            end
                        end
                    end
                end
                S_XMUL: r_state <= S_XSUM;
                S_XSUM: r_state <= S_YMUL;
                S_RD:   r_state <= S_YMUL;
                S_YMUL: begin
                    if (r_drain_mode || w_emit) begin
                        r_state <= S_YSUM;
                    end else if (w_more) begin
                        r_pass_b <= 1'b1;
                        r_pcol   <= r_col;
                        r_state  <= S_XMUL;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_YSUM: r_state <= S_YOUT;
                S_YOUT: begin
                    if (i_status.out_free) begin
                        if (r_drain_mode) begin
                            if (w_drain_last) begin
                                r_col   <= '0;
                                r_drain <= '0;
                                r_row   <= '0;
                                r_tail  <= '0;
                                r_head  <= '0;
                            end else begin
                                r_drain <= r_drain + AW'(1);
                            end
                            r_state <= S_IDLE;
                        end else if (w_more) begin
                            r_pass_b <= 1'b1;
                            r_pcol   <= r_col;
                            r_state  <= S_XMUL;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (w_col_last) begin
                        r_col  <= '0;
                        r_row  <= r_row + 16'd1;
                        r_tail <= w_tail_nx;
                        r_head <= w_head_nx;
                    end else begin
                        r_col <= r_col + AW'(1);
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall = (r_state != S_IDLE) || i_cfg_wr;
    assign o_col      = r_pcol;

    // Command decode.
    always_comb begin
        o_cmd            = '0;
        o_cmd.latch_in   = (r_state == S_IDLE) && i_in_valid && !i_cfg_wr &&
                           (i_op == sshp_pkg::OP_PUSH) && !w_row_done;
        o_cmd.shift_pix  = (r_state == S_FIN);
        o_cmd.phase_y    = (r_state == S_YMUL);
        o_cmd.tap_last   = r_pass_b;
        o_cmd.first_col  = (r_col == AW'(1));
        o_cmd.sum_en     = (r_state == S_XSUM) || (r_state == S_YSUM);
        o_cmd.wr_en      = (r_state == S_YMUL) && !r_drain_mode;
        o_cmd.below_rd   = r_drain_mode;
        o_cmd.above_slot = (r_drain_mode || r_row >= 16'd2) ? r_head : w_mid;
        o_cmd.mid_slot   = w_mid;
        o_cmd.tail_slot  = r_tail;
        o_cmd.load_out   = (r_state == S_YOUT) && i_status.out_free;
        o_cmd.row_end    = r_drain_mode ? w_drain_last : r_pass_b;
        o_cmd.frame_end  = r_drain_mode && w_drain_last;
        o_cmd.last_run   = r_drain_mode || r_pass_b || !w_col_last;
        o_cmd.n_eff      = w_n_eff;
    end

    // Once two rows are in, the oldest row and the row being written differ.
    a_ring_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row >= 16'd2) |-> (r_head != r_tail))
        else $error("ring head and tail point at the same row");

    // The x pass works on the column just before the current one, or on it.
    a_pass_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_XMUL) |-> (r_pcol == r_col || r_pcol == r_col - AW'(1)))
        else $error("x pass column is not next to the current column");

    // A result handed to the output register ends the output wait.
    a_out_leave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_YOUT && i_status.out_free) |=> (r_state != S_YOUT))
        else $error("sequencer stayed in output wait after loading a result");

endmodule
